### src/prrs_pkg.sv
`default_nettype none
package prrs_pkg;
	typedef enum logic [1:0] {
		MODE_NEXT = 2'd0,
		MODE_CREATE = 2'd1,
		MODE_TERM = 2'd2,
		MODE_CHPRI = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DISPATCHED = 2'd0,
		ST_IDLE = 2'd1,
		ST_DONE = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	localparam logic [1:0] LVL_CODE_HIGH = 2'b01;
	localparam logic [1:0] LVL_CODE_NORMAL = 2'b00;
	localparam logic [1:0] LVL_CODE_LOW = 2'b11;
	localparam int NUM_Q = 3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WALK_START,
		S_WALK_RD,
		S_WALK_CMP,
		S_WALK_NEXT,
		S_FIND_FREE,
		S_APPEND,
		S_APPEND_LINK,
		S_DISP_RD,
		S_DISP_DONE,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk_rd;
		logic walk_step;
		logic walk_unlink;
		logic free_init;
		logic free_step;
		logic append;
		logic append_link;
		logic disp_rd;
		logic disp_done;
		logic next_level;
		logic set_full;
	} cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic level_empty;
		logic walk_last;
		logic match;
		logic free_found;
		logic free_end;
		logic level_last;
		logic level_valid;
		logic any_nonempty;
		logic [1:0] mode;
	} stat_t;
endpackage
`default_nettype wire

### src/priority_round_robin_scheduler.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// request  in         in_valid / in_ready  mode, proc_id, level
// result   out        out_valid/out_ready  status, dispatched_id
//
// One request at a time. A dispatch reads the head entry, then updates the ring
// and gives its result; with nothing queued it reports idle without a read.
// Create scans the slots in order for the lowest free one; an invalid level
// gives its result without a scan. Terminate and change priority walk each
// level's ring, then change priority scans for a free slot as create does.
// Reset clears all slots and levels at once; the result holds until taken.
module priority_round_robin_scheduler #(
	parameter int MAX_ENTRIES = 64,
	parameter int ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic [15:0] proc_id,
	input wire logic signed [1:0] level,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [15:0] dispatched_id
);
	import prrs_pkg::*;

	cmd_t cmd;
	stat_t st;

	prrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_valid && in_ready), .out_fire(out_valid && out_ready),
		.st(st), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
	);

	prrs_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .ID_BITS(ID_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.mode(mode), .proc_id(proc_id), .level(level),
		.st(st), .status(status), .dispatched_id(dispatched_id)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("request taken while result pending");
	a_disp_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DISPATCHED |-> dispatched_id == '0)
		else $error("dispatched id not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

### src/prrs_ctrl.sv
`default_nettype none
module prrs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_fire,
	input wire prrs_pkg::stat_t st,
	output prrs_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	import prrs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.mode)
					MODE_NEXT: begin
						if (st.any_nonempty) begin
							state_d = S_DISP_RD;
						end else begin
							state_d = S_RESULT;
						end
					end
					MODE_CREATE: begin
						if (st.level_valid) begin
							cmd.free_init = 1'b1;
							state_d = S_FIND_FREE;
						end else begin
							state_d = S_RESULT;
						end
					end
					default: begin
						state_d = S_WALK_START;
					end
				endcase
			end
			S_WALK_START: begin
				if (st.level_empty) begin
					state_d = S_WALK_NEXT;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WALK_CMP;
			end
			S_WALK_CMP: begin
				if (st.match) begin
					cmd.walk_unlink = 1'b1;
					state_d = S_WALK_NEXT;
				end else if (st.walk_last) begin
					state_d = S_WALK_NEXT;
				end else begin
					cmd.walk_step = 1'b1;
					state_d = S_WALK_RD;
				end
			end
			S_WALK_NEXT: begin
				if (st.level_last) begin
					if (st.mode == MODE_CHPRI && st.level_valid) begin
						cmd.free_init = 1'b1;
						state_d = S_FIND_FREE;
					end else begin
						state_d = S_RESULT;
					end
				end else begin
					cmd.next_level = 1'b1;
					state_d = S_WALK_START;
				end
			end
			S_FIND_FREE: begin
				if (st.free_found) begin
					state_d = S_APPEND;
				end else if (st.free_end) begin
					cmd.set_full = 1'b1;
					state_d = S_RESULT;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d = S_APPEND_LINK;
			end
			S_APPEND_LINK: begin
				cmd.append_link = 1'b1;
				state_d = S_RESULT;
			end
			S_DISP_RD: begin
				cmd.disp_rd = 1'b1;
				state_d = S_DISP_DONE;
			end
			S_DISP_DONE: begin
				cmd.disp_done = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				out_valid = 1'b1;
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

### src/prrs_datapath.sv
`default_nettype none
module prrs_datapath #(
	parameter int MAX_ENTRIES = 64,
	parameter int ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire prrs_pkg::cmd_t cmd,
	input wire logic [1:0] mode,
	input wire logic [15:0] proc_id,
	input wire logic signed [1:0] level,
	output prrs_pkg::stat_t st,
	output logic [1:0] status,
	output logic [15:0] dispatched_id
);
	import prrs_pkg::*;

	localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_ENTRIES - 1);

	logic [ID_BITS-1:0] id_mem [MAX_ENTRIES];
	logic [SW-1:0] link_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] used_q;
	logic [SW-1:0] head_q [NUM_Q];
	logic [SW-1:0] tail_q [NUM_Q];
	logic [CW-1:0] count_q [NUM_Q];

	logic [1:0] mode_q;
	logic [ID_BITS-1:0] id_q;
	logic [1:0] lq_q;      // queue index; NUM_Q means invalid
	logic [1:0] wl_q;      // level being walked or dispatched
	logic [SW-1:0] cur_q, prev_q, free_q;
	logic [CW-1:0] iter_q;
	logic [ID_BITS-1:0] rd_id_q;
	logic [SW-1:0] rd_link_q;
	logic [1:0] status_q;
	logic [15:0] disp_q;

	logic [1:0] lq_d;
	logic [1:0] first_nz;

	always_comb begin
		case (level)
			LVL_CODE_HIGH: lq_d = 2'd0;
			LVL_CODE_NORMAL: lq_d = 2'd1;
			LVL_CODE_LOW: lq_d = 2'd2;
			default: lq_d = 2'(NUM_Q);
		endcase
		if (count_q[0] != '0) begin
			first_nz = 2'd0;
		end else if (count_q[1] != '0) begin
			first_nz = 2'd1;
		end else begin
			first_nz = 2'd2;
		end
	end

	assign st.mode = mode_q;
	assign st.level_valid = (lq_q != 2'(NUM_Q));
	assign st.any_nonempty = (count_q[0] != '0) || (count_q[1] != '0) || (count_q[2] != '0);
	assign st.level_empty = (count_q[wl_q] == '0);
	assign st.level_last = (wl_q == 2'(NUM_Q - 1));
	assign st.walk_last = (iter_q + CW'(1) >= count_q[wl_q]);
	assign st.match = (rd_id_q == id_q);
	assign st.free_found = !used_q[free_q];
	assign st.free_end = (free_q == LAST_SLOT);

	assign status = status_q;
	assign dispatched_id = disp_q;

	// Stores: one write port each, reads registered.
	always_ff @(posedge clk) begin
		if (cmd.walk_rd || cmd.disp_rd) begin
			rd_id_q <= id_mem[cur_q];
			rd_link_q <= link_mem[cur_q];
		end
		if (cmd.walk_unlink && count_q[wl_q] != CW'(1)) begin
			link_mem[prev_q] <= rd_link_q;
		end else if (cmd.append) begin
			link_mem[free_q] <= (count_q[lq_q] == '0) ? free_q : head_q[lq_q];
		end else if (cmd.append_link && count_q[lq_q] != CW'(1)) begin
			link_mem[tail_q[lq_q]] <= cur_q;
		end
		if (cmd.append) begin
			id_mem[free_q] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < NUM_Q; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				count_q[i] <= '0;
			end
			status_q <= ST_DONE;
			disp_q <= '0;
			mode_q <= '0;
			id_q <= '0;
			lq_q <= '0;
			wl_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			free_q <= '0;
			iter_q <= '0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode;
				id_q <= ID_BITS'(proc_id);
				lq_q <= lq_d;
				wl_q <= 2'd0;
				disp_q <= '0;
				status_q <= (mode == MODE_NEXT) ? ST_IDLE : ST_DONE;
			end
			if (mode_q == MODE_NEXT && !cmd.load && !cmd.disp_rd && !cmd.disp_done) begin
				wl_q <= first_nz;
				cur_q <= head_q[first_nz];
			end
			if (cmd.walk_init) begin
				cur_q <= head_q[wl_q];
				prev_q <= tail_q[wl_q];
				iter_q <= '0;
			end
			if (cmd.walk_step) begin
				prev_q <= cur_q;
				cur_q <= rd_link_q;
				iter_q <= iter_q + CW'(1);
			end
			if (cmd.walk_unlink) begin
				used_q[cur_q] <= 1'b0;
				if (count_q[wl_q] == CW'(1)) begin
					head_q[wl_q] <= '0;
					tail_q[wl_q] <= '0;
				end else begin
					if (cur_q == head_q[wl_q]) head_q[wl_q] <= rd_link_q;
					if (cur_q == tail_q[wl_q]) tail_q[wl_q] <= prev_q;
				end
				count_q[wl_q] <= count_q[wl_q] - CW'(1);
			end
			if (cmd.next_level) begin
				wl_q <= wl_q + 2'd1;
			end
			if (cmd.free_init) begin
				free_q <= '0;
			end
			if (cmd.free_step) begin
				free_q <= free_q + SW'(1);
			end
			if (cmd.set_full) begin
				status_q <= ST_FULL;
			end
			if (cmd.append) begin
				used_q[free_q] <= 1'b1;
				cur_q <= free_q;
				if (count_q[lq_q] == '0) head_q[lq_q] <= free_q;
				count_q[lq_q] <= count_q[lq_q] + CW'(1);
			end
			if (cmd.append_link) begin
				tail_q[lq_q] <= cur_q;
			end
			if (cmd.disp_done) begin
				disp_q <= 16'(rd_id_q);
				status_q <= ST_DISPATCHED;
				tail_q[wl_q] <= cur_q;
				head_q[wl_q] <= rd_link_q;
			end
		end
	end
endmodule
`default_nettype wire

### verif/priority_round_robin_scheduler_tb.sv
`timescale 1ns / 100ps
module priority_round_robin_scheduler_tb;
	import prrs_pkg::*;

	localparam int SLOTS = 64;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [15:0] proc_id;
	logic signed [1:0] level;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [15:0] dispatched_id;

	priority_round_robin_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .proc_id(proc_id), .level(level),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .dispatched_id(dispatched_id)
	);

	typedef struct packed {
		status_t st;
		logic [15:0] id;
	} sched_result_t;

	// Shadow copy of the scheduler state.
	logic [15:0] slot_id [SLOTS];
	int slot_next [SLOTS];
	bit slot_busy [SLOTS];
	int q_head [NUM_Q];
	int q_tail [NUM_Q];
	int q_len [NUM_Q];

	sched_result_t pending_results[$];
	int mismatches;
	int checked;
	int quiet_cycles;
	int idle_pct;
	bit out_stall_on;
	int n_dispatch, n_full, n_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int queue_of(logic [1:0] code);
		case (code)
			LVL_CODE_HIGH: return 0;
			LVL_CODE_NORMAL: return 1;
			LVL_CODE_LOW: return 2;
			default: return NUM_Q;
		endcase
	endfunction

	function automatic void unlink_first(int q, logic [15:0] pid);
		int cur;
		int prev;
		cur = q_head[q];
		prev = q_tail[q];
		for (int i = 0; i < q_len[q]; i++) begin
			if (slot_id[cur] == pid) begin
				slot_busy[cur] = 1'b0;
				if (q_len[q] == 1) begin
					q_len[q] = 0;
					q_head[q] = 0;
					q_tail[q] = 0;
					return;
				end
				slot_next[prev] = slot_next[cur];
				if (cur == q_head[q]) q_head[q] = slot_next[cur];
				if (cur == q_tail[q]) q_tail[q] = prev;
				q_len[q]--;
				return;
			end
			prev = cur;
			cur = slot_next[cur];
		end
	endfunction

	function automatic bit enqueue_id(int q, logic [15:0] pid);
		int s;
		s = 0;
		while (s < SLOTS && slot_busy[s]) s++;
		if (s >= SLOTS) return 1'b0;
		slot_busy[s] = 1'b1;
		slot_id[s] = pid;
		if (q_len[q] == 0) begin
			slot_next[s] = s;
			q_head[q] = s;
		end else begin
			slot_next[s] = q_head[q];
			slot_next[q_tail[q]] = s;
		end
		q_tail[q] = s;
		q_len[q]++;
		return 1'b1;
	endfunction

	function automatic sched_result_t schedule(logic [1:0] m, logic [15:0] pid,
			logic [1:0] lv);
		sched_result_t r;
		int q;
		int h;
		q = queue_of(lv);
		r.st = ST_DONE;
		r.id = '0;
		if (m == MODE_NEXT) begin
			r.st = ST_IDLE;
			for (int k = 0; k < NUM_Q; k++) begin
				if (q_len[k] != 0) begin
					h = q_head[k];
					r.id = slot_id[h];
					q_tail[k] = h;
					q_head[k] = slot_next[h];
					r.st = ST_DISPATCHED;
					break;
				end
			end
		end else if (m == MODE_CREATE) begin
			if (q < NUM_Q && !enqueue_id(q, pid)) r.st = ST_FULL;
		end else begin
			for (int k = 0; k < NUM_Q; k++) unlink_first(k, pid);
			if (m == MODE_CHPRI && q < NUM_Q && !enqueue_id(q, pid)) r.st = ST_FULL;
		end
		return r;
	endfunction

	function automatic int occupancy();
		return q_len[0] + q_len[1] + q_len[2];
	endfunction

	task automatic send_request(logic [1:0] m, logic [15:0] pid, logic [1:0] lv);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		mode <= m;
		proc_id <= pid;
		level <= lv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(schedule(m, pid, lv));
		in_valid <= 1'b0;
		// The block stays busy after taking a request until its result is taken.
		@(posedge clk);
	endtask

	// Result checker and stall generator on the output side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result status=%0d id=%h", status, dispatched_id);
				end else begin
					sched_result_t e;
					e = pending_results.pop_front();
					checked++;
					if (status != e.st || dispatched_id != e.id) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected status=%0d id=%h, got status=%0d id=%h",
								e.st, e.id, status, dispatched_id);
					end
					case (e.st)
						ST_DISPATCHED: n_dispatch++;
						ST_FULL: n_full++;
						ST_IDLE: n_idle++;
						default: ;
					endcase
				end
			end
			out_ready <= !(out_stall_on && $urandom_range(99) < 13);
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending_results.size());
			$display("FAIL priority_round_robin_scheduler");
			$finish;
		end
	end

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic test_idle_and_levels();
		send_request(MODE_NEXT, 16'h0000, LVL_CODE_NORMAL);
		send_request(MODE_CREATE, 16'hFFFF, LVL_CODE_LOW);
		send_request(MODE_CREATE, 16'h0000, LVL_CODE_NORMAL);
		send_request(MODE_CREATE, 16'hA5A5, LVL_CODE_HIGH);
		// The unused level code must be ignored by create.
		send_request(MODE_CREATE, 16'h1234, 2'b10);
		send_request(MODE_CREATE, 16'h5A5A, LVL_CODE_HIGH);
		repeat (3) send_request(MODE_NEXT, 16'hFFFF, 2'b10);
		drain();
	endtask

	task automatic test_remove_and_move();
		send_request(MODE_TERM, 16'hA5A5, LVL_CODE_HIGH);
		send_request(MODE_TERM, 16'h7777, LVL_CODE_HIGH);
		send_request(MODE_CREATE, 16'hFFFF, LVL_CODE_HIGH);
		send_request(MODE_CHPRI, 16'hFFFF, LVL_CODE_NORMAL);
		send_request(MODE_CHPRI, 16'h0000, 2'b10);
		send_request(MODE_CHPRI, 16'h4242, LVL_CODE_LOW);
		repeat (4) send_request(MODE_NEXT, 16'h0000, LVL_CODE_NORMAL);
		drain();
	endtask

	task automatic test_store_full();
		while (occupancy() < SLOTS)
			send_request(MODE_CREATE, 16'($urandom_range(7)), 2'($urandom_range(3)) | 2'b01);
		send_request(MODE_CREATE, 16'h0BAD, LVL_CODE_NORMAL);
		send_request(MODE_CHPRI, 16'h0BAD, LVL_CODE_HIGH);
		send_request(MODE_CHPRI, 16'h0003, LVL_CODE_HIGH);
		drain();
	endtask

	task automatic test_random_mix(int count);
		logic [1:0] m;
		logic [15:0] pid;
		for (int i = 0; i < count; i++) begin
			// Stretch from a third to half way through with no idling on either side.
			if (i == count / 3) begin
				idle_pct = 0;
				out_stall_on = 1'b0;
			end else if (i == count / 2) begin
				idle_pct = 13;
				out_stall_on = 1'b1;
			end
			// Small id pool so terminates and moves mostly find something.
			pid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
			case ($urandom_range(9))
				0, 1, 2: m = MODE_NEXT;
				3, 4, 5: m = (occupancy() > 56 && $urandom_range(3) != 0) ? MODE_TERM : MODE_CREATE;
				6, 7: m = MODE_TERM;
				default: m = MODE_CHPRI;
			endcase
			send_request(m, pid, 2'($urandom));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_NEXT;
		proc_id = '0;
		level = '0;
		out_ready = 1'b0;
		mismatches = 0;
		checked = 0;
		quiet_cycles = 0;
		idle_pct = 13;
		out_stall_on = 1'b1;
		n_dispatch = 0;
		n_full = 0;
		n_idle = 0;
		for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
		for (int q = 0; q < NUM_Q; q++) begin
			q_head[q] = 0;
			q_tail[q] = 0;
			q_len[q] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_levels();
		test_remove_and_move();
		test_store_full();
		test_random_mix(1150);
		$display("Checked %0d results: %0d dispatches, %0d idle, %0d store-full drops",
			checked, n_dispatch, n_idle, n_full);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS priority_round_robin_scheduler");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL priority_round_robin_scheduler");
		end
		$finish;
	end
endmodule

### priority_round_robin_scheduler.f
src/prrs_pkg.sv
src/prrs_ctrl.sv
src/prrs_datapath.sv
src/priority_round_robin_scheduler.sv
verif/priority_round_robin_scheduler_tb.sv
